@@ src/mits_pkg.sv @@
// ----------------------------------------------------------------------------
// META II token scanner package
// Shared types, token kind codes, character codes and the keyword table.
// ----------------------------------------------------------------------------
package mits_pkg;

    // Default longest identifier or string, in characters.
    localparam int MAX_TOKEN_LEN_DEF = 511;

    // Result field widths.
    localparam int KIND_W  = 5;
    localparam int START_W = 32;
    localparam int LEN_W   = 9;
    localparam int LINE_W  = 32;
    localparam int TOK_W   = KIND_W + START_W + LEN_W + LINE_W;
    localparam int TDATA_W = ((TOK_W + 7) / 8) * 8;

    // Token kinds.
    localparam logic [KIND_W-1:0] KIND_SYNTAX   = 5'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT    = 5'd8;
    localparam logic [KIND_W-1:0] KIND_STRING   = 5'd9;
    localparam logic [KIND_W-1:0] KIND_STAR     = 5'd10;
    localparam logic [KIND_W-1:0] KIND_STAR1    = 5'd11;
    localparam logic [KIND_W-1:0] KIND_STAR2    = 5'd12;
    localparam logic [KIND_W-1:0] KIND_DOLLAR   = 5'd13;
    localparam logic [KIND_W-1:0] KIND_LPAREN   = 5'd14;
    localparam logic [KIND_W-1:0] KIND_RPAREN   = 5'd15;
    localparam logic [KIND_W-1:0] KIND_EQUALS   = 5'd16;
    localparam logic [KIND_W-1:0] KIND_DOTCOMMA = 5'd17;
    localparam logic [KIND_W-1:0] KIND_SLASH    = 5'd18;
    localparam logic [KIND_W-1:0] KIND_END      = 5'd19;
    localparam logic [KIND_W-1:0] KIND_UNTERM   = 5'd20;
    localparam logic [KIND_W-1:0] KIND_TOOLONG  = 5'd21;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUOTE  = 8'h27;

    // Keyword spellings, padded with zeros to eight places.
    localparam int NUM_KW = 8;
    localparam logic [7:0] KW_CHARS [NUM_KW][8] = '{
        '{"S", "Y", "N", "T", "A", "X", 8'h00, 8'h00},
        '{"E", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"I", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"N", "U", "M", "B", "E", "R", 8'h00, 8'h00},
        '{"S", "T", "R", "I", "N", "G", 8'h00, 8'h00},
        '{"E", "M", "P", "T", "Y", 8'h00, 8'h00, 8'h00},
        '{"O", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"L", "A", "B", "E", "L", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_SIZE [NUM_KW] = '{
        3'd6, 3'd3, 3'd2, 3'd6, 3'd6, 3'd5, 3'd3, 3'd5
    };
    localparam logic [2:0] KW_MAX_LEN = 3'd6;

    // One result item.
    typedef struct packed {
        logic [LINE_W-1:0]  line;
        logic [LEN_W-1:0]   length;
        logic [START_W-1:0] start;
        logic [KIND_W-1:0]  kind;
        logic               last;
    } t_token;

    // Results of one scanned byte, first result in slot 0.
    typedef struct packed {
        logic   v0;
        logic   v1;
        t_token t0;
        t_token t1;
    } t_push;

endpackage

@@ src/mits_result_fifo.sv @@
// ----------------------------------------------------------------------------
// META II token scanner result queue
// Four-entry queue that takes up to two results per cycle and sends one while the sink is ready.
// ----------------------------------------------------------------------------
module mits_result_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mits_pkg::t_push i_push,
    output logic            o_room2,
    output logic            o_valid,
    input  logic            i_ready,
    output mits_pkg::t_token o_token
);
    import mits_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    t_token          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [PW:0]     r_count;
    logic [PW-1:0]   wr_ptr_1;
    logic            pop;
    logic [PW:0]     n_count;

    // Handshake and status.
    assign o_valid  = (r_count != '0);
    assign pop      = o_valid && i_ready;
    assign o_room2  = (r_count <= (PW+1)'(DEPTH - 2));
    assign o_token  = r_mem[r_rd_ptr];
    assign wr_ptr_1 = r_wr_ptr + 1'b1;

    always_comb begin
        n_count = r_count + (PW+1)'(i_push.v0) + (PW+1)'(i_push.v1) - (PW+1)'(pop);
    end

    // Storage, written at one or two consecutive places.
    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_push.t0;
        end
        if (i_push.v1) begin
            r_mem[wr_ptr_1] <= i_push.t1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PW'(i_push.v0) + PW'(i_push.v1);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

@@ src/mits_scan_core.sv @@
// ----------------------------------------------------------------------------
// META II token scanner core
// Holds the scan state and turns one byte into up to two token results.
// ----------------------------------------------------------------------------
module mits_scan_core #(
    parameter int MAX_TOKEN_LEN = mits_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    output mits_pkg::t_push o_push
);
    import mits_pkg::*;

    localparam int RW = $clog2(MAX_TOKEN_LEN + 1);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_DOT,
        MODE_KEYWORD,
        MODE_IDENT,
        MODE_STRING,
        MODE_STAR,
        MODE_HALT
    } t_mode;

    t_mode              r_mode,   n_mode;
    logic [NUM_KW-1:0]  r_cand,   n_cand;
    logic [2:0]         r_prefix, n_prefix;
    logic [START_W-1:0] r_start,  n_start;
    logic [RW-1:0]      r_run,    n_run;
    logic [START_W-1:0] r_offset;
    logic [LINE_W-1:0]  r_line,   n_line;

    logic               is_letter, is_alnum, is_blank;

    // Outcome of scanning the byte afresh.
    t_mode              f_mode;
    logic               f_set_start;
    logic               f_run_one;
    logic               f_newline;
    logic               f_emit;
    logic [KIND_W-1:0]  f_kind;
    logic [LEN_W-1:0]   f_len;

    // Keyword matching.
    logic [NUM_KW-1:0]  first_cand;
    logic [NUM_KW-1:0]  next_cand;
    logic               kw_hit;
    logic [KIND_W-1:0]  kw_kind;
    logic [2:0]         prefix_inc;

    // Identifier continuation and result slots.
    logic               do_ident;
    logic [RW-1:0]      id_len;
    logic [START_W-1:0] id_start;
    logic               do_fresh;
    logic               fresh_second;
    logic               e0, e1;
    logic [KIND_W-1:0]  k0, k1;
    logic [START_W-1:0] s0, s1;
    logic [LEN_W-1:0]   l0, l1;

    // Character classes.
    assign is_letter = ((i_byte >= "A") && (i_byte <= "Z")) ||
                       ((i_byte >= "a") && (i_byte <= "z"));
    assign is_alnum  = is_letter || ((i_byte >= "0") && (i_byte <= "9"));
    assign is_blank  = (i_byte == " ") || ((i_byte >= 8'd9) && (i_byte <= 8'd13));

    // Fresh scan of a byte outside any token.
    always_comb begin
        f_mode      = MODE_IDLE;
        f_set_start = 1'b0;
        f_run_one   = 1'b0;
        f_newline   = 1'b0;
        f_emit      = 1'b0;
        f_kind      = KIND_END;
        f_len       = LEN_W'(1);
        if (i_byte == CH_NUL) begin
            f_emit = 1'b1;
            f_kind = KIND_END;
            f_len  = '0;
            f_mode = MODE_HALT;
        end else if (is_blank) begin
            f_newline = (i_byte == CH_NL);
        end else if (i_byte == CH_DOT) begin
            f_mode      = MODE_DOT;
            f_set_start = 1'b1;
        end else if (is_letter) begin
            f_mode      = MODE_IDENT;
            f_set_start = 1'b1;
            f_run_one   = 1'b1;
        end else if (i_byte == CH_QUOTE) begin
            f_mode      = MODE_STRING;
            f_set_start = 1'b1;
            f_run_one   = 1'b1;
        end else if (i_byte == CH_STAR) begin
            f_mode      = MODE_STAR;
            f_set_start = 1'b1;
        end else begin
            case (i_byte)
                CH_DOLLAR: begin
                    f_emit = 1'b1;
                    f_kind = KIND_DOLLAR;
                end
                CH_LPAREN: begin
                    f_emit = 1'b1;
                    f_kind = KIND_LPAREN;
                end
                CH_RPAREN: begin
                    f_emit = 1'b1;
                    f_kind = KIND_RPAREN;
                end
                CH_EQUALS: begin
                    f_emit = 1'b1;
                    f_kind = KIND_EQUALS;
                end
                CH_SLASH: begin
                    f_emit = 1'b1;
                    f_kind = KIND_SLASH;
                end
                default: begin
                    f_emit = 1'b0;
                end
            endcase
        end
    end

    // Keyword candidate sets for the first letter and for later letters.
    assign prefix_inc = r_prefix + 1'b1;

    always_comb begin
        first_cand = '0;
        next_cand  = '0;
        for (int k = 0; k < NUM_KW; k++) begin
            first_cand[k] = (KW_CHARS[k][0] == i_byte);
            next_cand[k]  = r_cand[k] && (r_prefix < KW_MAX_LEN) &&
                            (r_prefix < KW_SIZE[k]) &&
                            (KW_CHARS[k][r_prefix] == i_byte);
        end
    end

    // Lowest keyword that is complete after this letter.
    always_comb begin
        kw_hit  = 1'b0;
        kw_kind = KIND_SYNTAX;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (next_cand[k] && (KW_SIZE[k] == prefix_inc)) begin
                kw_hit  = 1'b1;
                kw_kind = KIND_W'(k);
            end
        end
    end

    // Next state and results for one byte.
    always_comb begin
        n_mode       = r_mode;
        n_cand       = r_cand;
        n_prefix     = r_prefix;
        n_start      = r_start;
        n_run        = r_run;
        n_line       = r_line;
        do_ident     = 1'b0;
        id_len       = r_run;
        id_start     = r_start;
        do_fresh     = 1'b0;
        fresh_second = 1'b0;
        e0 = 1'b0;
        k0 = KIND_END;
        s0 = r_start;
        l0 = '0;
        e1 = 1'b0;
        k1 = KIND_END;
        s1 = r_offset;
        l1 = '0;

        unique case (r_mode)
            MODE_DOT: begin
                if (i_byte == CH_COMMA) begin
                    e0     = 1'b1;
                    k0     = KIND_DOTCOMMA;
                    l0     = LEN_W'(2);
                    n_mode = MODE_IDLE;
                end else if (is_letter) begin
                    if (first_cand != '0) begin
                        n_mode   = MODE_KEYWORD;
                        n_cand   = first_cand;
                        n_prefix = 3'd1;
                    end else begin
                        n_mode  = MODE_IDENT;
                        n_start = r_offset;
                        n_run   = RW'(1);
                    end
                end else begin
                    do_fresh = 1'b1;
                end
            end
            MODE_KEYWORD: begin
                if (next_cand != '0) begin
                    n_prefix = prefix_inc;
                    n_cand   = next_cand;
                    if (kw_hit) begin
                        e0     = 1'b1;
                        k0     = kw_kind;
                        l0     = LEN_W'(prefix_inc) + LEN_W'(1);
                        n_mode = MODE_IDLE;
                    end
                end else begin
                    // The dot is dropped; the letters seen so far form an identifier.
                    do_ident = 1'b1;
                    id_len   = RW'(r_prefix);
                    id_start = r_start + 1'b1;
                    n_mode   = MODE_IDENT;
                    n_start  = id_start;
                    n_run    = id_len;
                end
            end
            MODE_IDENT: begin
                do_ident = 1'b1;
            end
            MODE_STRING: begin
                if ((i_byte == CH_NUL) || (i_byte == CH_NL)) begin
                    e0     = 1'b1;
                    k0     = KIND_UNTERM;
                    l0     = LEN_W'(r_run);
                    n_mode = MODE_HALT;
                end else if (r_run >= RW'(MAX_TOKEN_LEN)) begin
                    e0     = 1'b1;
                    k0     = KIND_TOOLONG;
                    l0     = LEN_W'(r_run);
                    n_mode = MODE_HALT;
                end else begin
                    n_run = r_run + 1'b1;
                    if (i_byte == CH_QUOTE) begin
                        e0     = 1'b1;
                        k0     = KIND_STRING;
                        l0     = LEN_W'(n_run);
                        n_mode = MODE_IDLE;
                    end
                end
            end
            MODE_STAR: begin
                e0 = 1'b1;
                if (i_byte == CH_ONE) begin
                    k0     = KIND_STAR1;
                    l0     = LEN_W'(2);
                    n_mode = MODE_IDLE;
                end else if (i_byte == CH_TWO) begin
                    k0     = KIND_STAR2;
                    l0     = LEN_W'(2);
                    n_mode = MODE_IDLE;
                end else begin
                    k0           = KIND_STAR;
                    l0           = LEN_W'(1);
                    do_fresh     = 1'b1;
                    fresh_second = 1'b1;
                end
            end
            MODE_HALT: begin
                n_mode = MODE_HALT;
            end
            default: begin
                do_fresh = 1'b1;
            end
        endcase

        // Identifier body: grow, overflow, or end and rescan the byte.
        if (do_ident) begin
            if (is_alnum) begin
                if (id_len >= RW'(MAX_TOKEN_LEN)) begin
                    e0     = 1'b1;
                    k0     = KIND_TOOLONG;
                    s0     = id_start;
                    l0     = LEN_W'(id_len);
                    n_mode = MODE_HALT;
                end else begin
                    n_run = id_len + 1'b1;
                end
            end else begin
                e0           = 1'b1;
                k0           = KIND_IDENT;
                s0           = id_start;
                l0           = LEN_W'(id_len);
                do_fresh     = 1'b1;
                fresh_second = 1'b1;
            end
        end

        // Fresh scan, as first or second result of the byte.
        if (do_fresh) begin
            n_mode = f_mode;
            if (f_set_start) begin
                n_start = r_offset;
            end
            if (f_run_one) begin
                n_run = RW'(1);
            end
            if (f_newline && (r_line != '1)) begin
                n_line = r_line + 1'b1;
            end
            if (fresh_second) begin
                e1 = f_emit;
                k1 = f_kind;
                s1 = r_offset;
                l1 = f_len;
            end else begin
                e0 = f_emit;
                k0 = f_kind;
                s0 = r_offset;
                l0 = f_len;
            end
        end
    end

    // Results toward the queue; all results of a byte share the line count.
    always_comb begin
        o_push.v0        = i_step && (r_mode != MODE_HALT) && e0;
        o_push.v1        = i_step && (r_mode != MODE_HALT) && e1;
        o_push.t0.kind   = k0;
        o_push.t0.start  = s0;
        o_push.t0.length = l0;
        o_push.t0.line   = r_line;
        o_push.t0.last   = !e1;
        o_push.t1.kind   = k1;
        o_push.t1.start  = s1;
        o_push.t1.length = l1;
        o_push.t1.line   = r_line;
        o_push.t1.last   = 1'b1;
    end

    // Scan state; a halted scanner ignores every byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_cand   <= '0;
            r_prefix <= '0;
            r_start  <= '0;
            r_run    <= '0;
            r_offset <= '0;
            r_line   <= LINE_W'(1);
        end else if (i_step && (r_mode != MODE_HALT)) begin
            r_mode   <= n_mode;
            r_cand   <= n_cand;
            r_prefix <= n_prefix;
            r_start  <= n_start;
            r_run    <= n_run;
            r_offset <= r_offset + 1'b1;
            r_line   <= n_line;
        end
    end

endmodule

@@ src/meta_ii_token_scanner_unit.sv @@
// ----------------------------------------------------------------------------
// META II token scanner
// Scans source text one byte at a time and streams out token results.
// ----------------------------------------------------------------------------
// Path: a token passes the input register, then the result queue; a second one follows.
// Throughput: one byte per cycle; two-result bytes are always apart by a byte with none,
// so the four-entry queue keeps pace with a ready sink and stalls only under backpressure.
// Reset: synchronous, active low; the scanner returns to idle at offset 0,
// line 1, and the result queue empties.
module meta_ii_token_scanner_unit #(
    parameter int MAX_TOKEN_LEN = mits_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // text_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // token_kind, token_start, token_length, token_line, zero fill
    output logic [mits_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                         m_axis_tlast   // last_of_byte
);
    import mits_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       room2;
    logic       step;
    t_push      push;
    t_token     token;

    // A held byte is scanned once the queue has room for two results.
    assign step          = r_in_valid && room2;
    assign s_axis_tready = !r_in_valid || step;

    // Input request register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    mits_scan_core #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_push  (push)
    );

    mits_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_token (token)
    );

    // Output packing, first field in the lowest bits.
    assign m_axis_tdata = TDATA_W'({token.line, token.length, token.start, token.kind});
    assign m_axis_tlast = token.last;

endmodule
